@@ rtl/cwsk_pkg.sv @@
// shared types and constants for the wheel speed kinematics core
// holds the cordic datapath word and the arctangent table
// no dependencies
package cwsk_pkg;

    // cordic datapath width, q30 values with headroom
    localparam int CW = 34;
    localparam int MAX_TRIG = 24;

    // cordic gain 0.607252935 in q30
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

    // minus 57.2958 in q16, negation folded into the constant
    localparam logic signed [23:0] NEG_DEG_PER_RAD = -24'sd3754938;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_t;

    // atan(2^-i) in 2^32 per turn units
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2FA;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/cwsk_cordic_stage.sv @@
// one registered rotation step of the cordic sine/cosine pipeline
// depends on cwsk_pkg for the datapath word and the arctangent table
module cwsk_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              en,
    input  cwsk_pkg::cordic_t d,
    output cwsk_pkg::cordic_t q
);
    import cwsk_pkg::*;

    localparam logic signed [CW-1:0] ATAN = $signed({{(CW-32){1'b0}}, atan_turn(STAGE)});

    cordic_t q_reg;
    cordic_t q_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = d.y >>> STAGE;
    assign dy = d.x >>> STAGE;

    // residual angle zero counts as positive
    always_comb
    begin
        q_next.flip = d.flip;
        if (!d.z[CW-1])
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - ATAN;
        end
        else
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/chassis_wheel_speed_kinematics_core.sv @@
// four wheel omni/mecanum inverse kinematics core, top level
// depends on cwsk_pkg and cwsk_cordic_stage
//
// usage
// - input channel (in_valid/in_ready) takes one chassis command beat:
//   speed and turn_rate in signed q4.12, heading as a binary angle
// - output channel (out_valid/out_ready) gives one beat per command: four
//   wheel targets in signed q15.8 deg/s (rf, lf, lr, rr) and a flag that
//   is set when any wheel was clipped to the 24 bit range
// - apb port holds the translation gain (0x0) and the rotation gain (0x4),
//   both q8.8; write them only while no command is in flight
// - the pipeline has one input stage, one stage per cordic step and six
//   multiply/round stages
// - throughput is one beat per cycle while out_ready stays high; every
//   stage has its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles close up and the input keeps taking beats
//   while a result waits
// - when the receiver stalls the pipeline fills and in_ready drops once
//   every stage holds a beat; nothing is dropped or repeated
// - reset empties the pipeline and loads translation gain 2304,
//   rotation gain 1024
module chassis_wheel_speed_kinematics_core #(
    parameter int ANGLE_BITS  = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // apb configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] speed,
    input  logic [15:0]        heading,
    input  logic signed [15:0] turn_rate,
    // wheel target channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] wheel_rf_speed,
    output logic signed [23:0] wheel_lf_speed,
    output logic signed [23:0] wheel_lr_speed,
    output logic signed [23:0] wheel_rr_speed,
    output logic               saturated
);
    import cwsk_pkg::*;

    // cordic steps beyond the table add nothing
    localparam int N  = (TRIG_STAGES > MAX_TRIG) ? MAX_TRIG : TRIG_STAGES;
    // stage map: 0 input, 1..N cordic, N+1..N+5 math, N+6 output
    localparam int S_M1  = N + 1;
    localparam int S_M2  = N + 2;
    localparam int S_M3  = N + 3;
    localparam int S_M4  = N + 4;
    localparam int S_M5  = N + 5;
    localparam int S_OUT = N + 6;
    localparam int NS    = N + 7;

    localparam int SUMW = 47;
    localparam int PW   = SUMW + 24;

    typedef enum logic {
        REG_TRANS_GAIN = 1'b0,
        REG_TURN_GAIN  = 1'b1
    } reg_idx_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] trans_gain_reg;
    logic [15:0] turn_gain_reg;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_gain_reg <= 16'd2304;
            turn_gain_reg  <= 16'd1024;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_TRANS_GAIN: trans_gain_reg <= pwdata[15:0];
                REG_TURN_GAIN:  turn_gain_reg  <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TRANS_GAIN: prdata = {16'd0, trans_gain_reg};
            REG_TURN_GAIN:  prdata = {16'd0, turn_gain_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when its beat moves on
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    assign en[NS-1] = !valid_reg[NS-1] || out_ready;

    for (genvar k = 0; k < NS - 1; k++)
    begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    // ------------------------------------------------------------------
    // stage 0: phase and quadrant fold
    // ------------------------------------------------------------------
    logic [31:0] heading_wide;
    logic [31:0] phase;
    logic        quad_flip;
    cordic_t     cin_next;

    assign heading_wide = {16'd0, heading};
    // shift drops the bits above the angle width
    assign phase        = heading_wide << (32 - ANGLE_BITS);
    // second or third quadrant: rotate by half a turn, negate at the end
    assign quad_flip    = phase[31] ^ phase[30];

    always_comb
    begin
        cin_next.x    = CORDIC_K;
        cin_next.y    = '0;
        cin_next.z    = $signed({{(CW-31){phase[31] ^ quad_flip}}, phase[30:0]});
        cin_next.flip = quad_flip;
    end

    cordic_t            cstg [0:N];
    logic signed [15:0] spd_reg  [0:N];
    logic signed [15:0] turn_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cstg[0]     <= cin_next;
            spd_reg[0]  <= speed;
            turn_reg[0] <= turn_rate;
        end
    end

    // ------------------------------------------------------------------
    // cordic rotation steps, one per stage; speed and turn ride alongside
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= N; k++)
    begin : g_cordic
        cwsk_cordic_stage #(
            .STAGE (k - 1)
        ) u_stage (
            .clk (clk),
            .en  (en[k]),
            .d   (cstg[k-1]),
            .q   (cstg[k])
        );

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                spd_reg[k]  <= spd_reg[k-1];
                turn_reg[k] <= turn_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // m1: undo the quadrant fold, form cos-sin and sin+cos, rotation product
    // ------------------------------------------------------------------
    logic signed [CW:0] cx;
    logic signed [CW:0] cy;
    logic signed [CW:0] a_next;
    logic signed [CW:0] b_next;
    logic signed [32:0] rot_next;
    logic signed [CW:0] a_reg;
    logic signed [CW:0] b_reg;
    logic signed [32:0] rot1_reg;
    logic signed [15:0] spd1_reg;

    assign cx       = {cstg[N].x[CW-1], cstg[N].x};
    assign cy       = {cstg[N].y[CW-1], cstg[N].y};
    assign a_next   = cstg[N].flip ? (cy - cx) : (cx - cy);
    assign b_next   = cstg[N].flip ? (-cx - cy) : (cx + cy);
    assign rot_next = turn_reg[N] * $signed({1'b0, turn_gain_reg});

    always_ff @(posedge clk)
    begin
        if (en[S_M1])
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            rot1_reg <= rot_next;
            spd1_reg <= spd_reg[N];
        end
    end

    // ------------------------------------------------------------------
    // m2: speed times trig terms, rounded q42 to q20
    // ------------------------------------------------------------------
    logic signed [CW+16:0] pa;
    logic signed [CW+16:0] pb;
    logic signed [CW+16:0] pa_rnd;
    logic signed [CW+16:0] pb_rnd;
    logic signed [CW-6:0]  qa_reg;
    logic signed [CW-6:0]  qb_reg;
    logic signed [32:0]    rot2_reg;

    assign pa     = spd1_reg * a_reg;
    assign pb     = spd1_reg * b_reg;
    assign pa_rnd = pa + ((CW+17)'(1) <<< 21);
    assign pb_rnd = pb + ((CW+17)'(1) <<< 21);

    always_ff @(posedge clk)
    begin
        if (en[S_M2])
        begin
            qa_reg   <= pa_rnd[CW+16:22];
            qb_reg   <= pb_rnd[CW+16:22];
            rot2_reg <= rot1_reg;
        end
    end

    // ------------------------------------------------------------------
    // m3: translation gain, rotation term to q28
    // ------------------------------------------------------------------
    logic signed [45:0] xg_reg;
    logic signed [45:0] yg_reg;
    logic signed [40:0] rot3_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_M3])
        begin
            xg_reg   <= qa_reg * $signed({1'b0, trans_gain_reg});
            yg_reg   <= qb_reg * $signed({1'b0, trans_gain_reg});
            rot3_reg <= {rot2_reg, 8'd0};
        end
    end

    // ------------------------------------------------------------------
    // m4: wheel sums, rf = yg+rot, lf = rot-xg, lr = rot-yg, rr = xg+rot
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] xg_w;
    logic signed [SUMW-1:0] yg_w;
    logic signed [SUMW-1:0] rot_w;
    logic signed [SUMW-1:0] sum_rf_reg;
    logic signed [SUMW-1:0] sum_lf_reg;
    logic signed [SUMW-1:0] sum_lr_reg;
    logic signed [SUMW-1:0] sum_rr_reg;

    assign xg_w  = SUMW'(xg_reg);
    assign yg_w  = SUMW'(yg_reg);
    assign rot_w = SUMW'(rot3_reg);

    always_ff @(posedge clk)
    begin
        if (en[S_M4])
        begin
            sum_rf_reg <= yg_w + rot_w;
            sum_lf_reg <= rot_w - xg_w;
            sum_lr_reg <= rot_w - yg_w;
            sum_rr_reg <= xg_w + rot_w;
        end
    end

    // ------------------------------------------------------------------
    // m5: negate and scale rad to deg
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_rf_reg;
    logic signed [PW-1:0] prod_lf_reg;
    logic signed [PW-1:0] prod_lr_reg;
    logic signed [PW-1:0] prod_rr_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_M5])
        begin
            prod_rf_reg <= sum_rf_reg * NEG_DEG_PER_RAD;
            prod_lf_reg <= sum_lf_reg * NEG_DEG_PER_RAD;
            prod_lr_reg <= sum_lr_reg * NEG_DEG_PER_RAD;
            prod_rr_reg <= sum_rr_reg * NEG_DEG_PER_RAD;
        end
    end

    // ------------------------------------------------------------------
    // output stage: round q44 to q8 and clip to 24 bits
    // ------------------------------------------------------------------
    // returns {clipped, value}
    function automatic logic [24:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        logic signed [PW-37:0] v;
        logic [24:0] res;
        r = p + ((PW)'(1) <<< 35);
        v = r[PW-1:36];
        if (v > (PW-36)'(24'sh7FFFFF))
        begin
            res = {1'b1, 24'h7FFFFF};
        end
        else if (v < -(PW-36)'(25'sd8388608))
        begin
            res = {1'b1, 24'h800000};
        end
        else
        begin
            res = {1'b0, v[23:0]};
        end
        return res;
    endfunction

    logic [24:0]        rs_rf;
    logic [24:0]        rs_lf;
    logic [24:0]        rs_lr;
    logic [24:0]        rs_rr;
    logic signed [23:0] wheel_rf_reg;
    logic signed [23:0] wheel_lf_reg;
    logic signed [23:0] wheel_lr_reg;
    logic signed [23:0] wheel_rr_reg;
    logic               sat_reg;

    assign rs_rf = round_sat(prod_rf_reg);
    assign rs_lf = round_sat(prod_lf_reg);
    assign rs_lr = round_sat(prod_lr_reg);
    assign rs_rr = round_sat(prod_rr_reg);

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            wheel_rf_reg <= rs_rf[23:0];
            wheel_lf_reg <= rs_lf[23:0];
            wheel_lr_reg <= rs_lr[23:0];
            wheel_rr_reg <= rs_rr[23:0];
            sat_reg      <= rs_rf[24] | rs_lf[24] | rs_lr[24] | rs_rr[24];
        end
    end

    assign wheel_rf_speed = wheel_rf_reg;
    assign wheel_lf_speed = wheel_lf_reg;
    assign wheel_lr_speed = wheel_lr_reg;
    assign wheel_rr_speed = wheel_rr_reg;
    assign saturated      = sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a full pipeline behind a stalled receiver must refuse new beats
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("in_ready high with full pipeline and stalled output");

    // a held beat in the last cordic stage is not lost
    a_cordic_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] && !en[N] |=> valid_reg[N])
        else $error("stalled beat dropped from cordic pipeline");

    // the clip flag implies at least one wheel sits at a range limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (wheel_rf_speed == 24'sh7FFFFF) || (wheel_rf_speed == -24'sh800000) ||
            (wheel_lf_speed == 24'sh7FFFFF) || (wheel_lf_speed == -24'sh800000) ||
            (wheel_lr_speed == 24'sh7FFFFF) || (wheel_lr_speed == -24'sh800000) ||
            (wheel_rr_speed == 24'sh7FFFFF) || (wheel_rr_speed == -24'sh800000))
        else $error("saturated flag set with no wheel at a limit");

endmodule

@@ bench/cwsk_checker.sv @@
`timescale 1ns / 100ps
// register codes shared by the bench files, plus the scoreboard for the kinematics core
// watches the apb port and both beat channels and predicts each wheel target set
// depends on nothing but the signals it is connected to
package cwsk_tb_defs;

    typedef enum logic [0:0] {
        REG_TRANS_GAIN = 1'b0,
        REG_TURN_GAIN  = 1'b1
    } reg_index_e;

    typedef struct packed {
        logic [23:0] rf;
        logic [23:0] lf;
        logic [23:0] lr;
        logic [23:0] rr;
        logic        sat;
    } wheel_set_t;

endpackage

module cwsk_checker #(
    parameter int ANGLE_BITS  = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] speed,
    input  logic [15:0] heading,
    input  logic [15:0] turn_rate,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] wheel_rf_speed,
    input  logic [23:0] wheel_lf_speed,
    input  logic [23:0] wheel_lr_speed,
    input  logic [23:0] wheel_rr_speed,
    input  logic        saturated,
    output int          fail_count,
    output int          pending
);
    import cwsk_tb_defs::*;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint DEG_PER_RAD = 64'sd3754938;
    localparam longint WHEEL_MAX   = 64'sd8388607;
    localparam longint WHEEL_MIN   = -64'sd8388608;

    // arctangent of 2^-i, 2^32 per turn
    localparam logic [0:23][31:0] ATAN_TURN = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic [15:0] move_gain = 16'd2304;
    logic [15:0] rot_gain  = 16'd1024;
    wheel_set_t  wheel_q [$];
    int          errors = 0;

    function automatic wheel_set_t predict_wheels(
        input logic [15:0] spd_raw,
        input logic [15:0] hdg,
        input logic [15:0] turn_raw,
        input logic [15:0] mscale,
        input logic [15:0] rscale
    );
        wheel_set_t  res;
        logic [31:0] phase;
        logic        flip;
        longint      cx, sy, z, dx, dy, step;
        longint      spd, turn, ms, rs, xg, yg, rot, prod;
        longint      sum [4];
        logic [23:0] wheel [4];
        int          i;
        res.sat = 1'b0;
        phase = ({16'h0, hdg} & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
        // second and third quadrant: rotate by half a turn, negate at the end
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip)
            phase = phase + 32'h8000_0000;
        z  = $signed(phase);
        cx = GAIN_Q30;
        sy = 0;
        for (i = 0; i < TRIG_STAGES && i < 24; i++)
        begin
            dx   = sy >>> i;
            dy   = cx >>> i;
            step = ATAN_TURN[i];
            if (z >= 0)
            begin
                cx = cx - dx;
                sy = sy + dy;
                z  = z - step;
            end
            else
            begin
                cx = cx + dx;
                sy = sy - dy;
                z  = z + step;
            end
        end
        if (flip)
        begin
            cx = -cx;
            sy = -sy;
        end
        spd  = $signed(spd_raw);
        turn = $signed(turn_raw);
        ms   = mscale;
        rs   = rscale;
        xg   = ((spd * (cx - sy) + (64'sd1 <<< 21)) >>> 22) * ms;
        yg   = ((spd * (sy + cx) + (64'sd1 <<< 21)) >>> 22) * ms;
        rot  = turn * rs * 64'sd256;
        sum[0] = yg + rot;
        sum[1] = rot - xg;
        sum[2] = rot - yg;
        sum[3] = xg + rot;
        for (i = 0; i < 4; i++)
        begin
            prod = ((-sum[i]) * DEG_PER_RAD + (64'sd1 <<< 35)) >>> 36;
            if (prod > WHEEL_MAX)
            begin
                prod    = WHEEL_MAX;
                res.sat = 1'b1;
            end
            if (prod < WHEEL_MIN)
            begin
                prod    = WHEEL_MIN;
                res.sat = 1'b1;
            end
            wheel[i] = prod[23:0];
        end
        res.rf = wheel[0];
        res.lf = wheel[1];
        res.lr = wheel[2];
        res.rr = wheel[3];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wheel_set_t want;
        if (!rst_n)
        begin
            move_gain = 16'd2304;
            rot_gain  = 16'd1024;
            wheel_q.delete();
            pending    <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_index_e'(paddr[2]))
                        REG_TRANS_GAIN: move_gain = pwdata[15:0];
                        REG_TURN_GAIN:  rot_gain  = pwdata[15:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (reg_index_e'(paddr[2]))
                        REG_TRANS_GAIN: want.rf = move_gain;
                        default:        want.rf = rot_gain;
                    endcase
                    if (prdata !== {8'h0, want.rf})
                    begin
                        $display("%0t ns: register readback expected %0d got %0d",
                                 $time, want.rf, prdata);
                        errors++;
                    end
                end
            end
            if (out_valid === 1'b1 && out_ready)
            begin
                if (wheel_q.size() == 0)
                begin
                    $display("%0t ns: wheel beat with nothing expected, expected none got rf %0d",
                             $time, $signed(wheel_rf_speed));
                    errors++;
                end
                else
                begin
                    want = wheel_q.pop_front();
                    check_field("wheel_rf_speed", want.rf, wheel_rf_speed);
                    check_field("wheel_lf_speed", want.lf, wheel_lf_speed);
                    check_field("wheel_lr_speed", want.lr, wheel_lr_speed);
                    check_field("wheel_rr_speed", want.rr, wheel_rr_speed);
                    check_field("saturated", {23'h0, want.sat}, {23'h0, saturated});
                end
            end
            if (in_valid && in_ready === 1'b1)
                wheel_q.push_back(predict_wheels(speed, heading, turn_rate, move_gain, rot_gain));
            pending    <= wheel_q.size();
            fail_count <= errors;
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// top of the bench for the wheel speed kinematics core: clock, reset, stimulus, verdict
// depends on cwsk_checker.sv (cwsk_tb_defs and cwsk_checker) and the core rtl
module testbench;

    import cwsk_tb_defs::*;

    localparam int   ANGLE_BITS  = 16;
    localparam int   TRIG_STAGES = 16;
    // input beat to output beat, through every pipeline stage of the core
    localparam int   LATENCY     = TRIG_STAGES + 7;
    localparam logic APB_WRITE   = 1'b1;
    localparam logic APB_READ    = 1'b0;

    // directed commands, {speed, heading, turn_rate}
    localparam logic [0:19][47:0] DIRECTED_CMDS = {
        48'h0000_0000_0000,  // all zero
        48'h7FFF_0000_0000,  // full forward speed, heading zero
        48'h8000_0000_0000,  // full reverse speed
        48'h7FFF_4000_0000,  // quadrant boundaries
        48'h7FFF_8000_0000,
        48'h7FFF_C000_0000,
        48'h7FFF_FFFF_0000,  // top of the heading range
        48'h8000_3FFF_0000,  // just either side of the flipped quadrants
        48'h8000_4001_0000,
        48'h8000_BFFF_0000,
        48'h8000_C001_0000,
        48'h7FFF_2000_0000,  // 45 deg, cos minus sin cancels
        48'h7FFF_6000_0000,  // 135 deg
        48'h0000_0000_7FFF,  // pure rotation, both extremes
        48'h0000_0000_8000,
        48'h7FFF_2000_7FFF,  // translation and rotation add up
        48'h8000_A000_8000,
        48'h0001_1234_FFFF,  // smallest magnitudes
        48'hFFFF_E000_0001,
        48'h7FFF_E000_8000
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [15:0] speed, heading, turn_rate;
    logic        out_valid, out_ready;
    logic [23:0] wheel_rf_speed, wheel_lf_speed, wheel_lr_speed, wheel_rr_speed;
    logic        saturated;
    int          fail_count, pending;

    // stimulus bookkeeping
    logic        src_steady;   // sender offers back to back while set
    logic        hold_req;     // asks the receiver for one long stall
    int          n_cmds, n_settings, n_reads;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    chassis_wheel_speed_kinematics_core #(
        .ANGLE_BITS  (ANGLE_BITS),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .speed          (speed),
        .heading        (heading),
        .turn_rate      (turn_rate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .wheel_rf_speed (wheel_rf_speed),
        .wheel_lf_speed (wheel_lf_speed),
        .wheel_lr_speed (wheel_lr_speed),
        .wheel_rr_speed (wheel_rr_speed),
        .saturated      (saturated)
    );

    cwsk_checker #(
        .ANGLE_BITS  (ANGLE_BITS),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .speed          (speed),
        .heading        (heading),
        .turn_rate      (turn_rate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .wheel_rf_speed (wheel_rf_speed),
        .wheel_lf_speed (wheel_lf_speed),
        .wheel_lr_speed (wheel_lr_speed),
        .wheel_rr_speed (wheel_rr_speed),
        .saturated      (saturated),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // field values: mostly uniform, with a share of extremes, small values
    // around zero and headings right at a quadrant boundary
    function automatic logic [15:0] rand_word();
        logic [15:0] w;
        case ($urandom_range(0, 9))
            6:       w = 16'h8000;
            7:       w = 16'h7FFF;
            8:       w = 16'($urandom_range(0, 255)) - 16'd128;
            9:       w = {2'($urandom_range(0, 3)), 14'h0} + 16'($urandom_range(0, 2)) - 16'd1;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    // one command beat; entered and left at a rising edge. valid is only
    // dropped when a gap is drawn, so back to back beats keep it high
    task automatic send_cmd(input logic [15:0] spd, input logic [15:0] hdg,
                            input logic [15:0] turn);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        speed     <= spd;
        heading   <= hdg;
        turn_rate <= turn;
        do @(posedge clk); while (in_ready !== 1'b1);
        n_cmds++;
    endtask

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            // switch between idling and back to back stretches now and then
            if ($urandom_range(0, 39) == 0)
                src_steady = !src_steady;
            send_cmd(rand_word(), rand_word(), rand_word());
        end
    endtask

    // stop offering and wait until every expected wheel beat has come out,
    // then give the pipeline its latency before touching registers
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // setup then access phase; psel is then dropped and the task waits before
    // returning, so that back to back transfers never assign psel twice in one step
    task automatic apb_xfer(input logic wr, input reg_index_e idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (wr == APB_READ)
            n_reads++;
    endtask

    task automatic set_gains(input logic [15:0] mg, input logic [15:0] rg);
        drain_pipeline();
        // junk in the upper data bits, the registers are 16 bits wide
        apb_xfer(APB_WRITE, REG_TRANS_GAIN, {16'($urandom), mg});
        apb_xfer(APB_WRITE, REG_TURN_GAIN, {16'($urandom), rg});
        apb_xfer(APB_READ, REG_TRANS_GAIN, 32'h0);
        apb_xfer(APB_READ, REG_TURN_GAIN, 32'h0);
        n_settings++;
    endtask

    // receiver: a random stall before each beat, stretches of steady
    // ready, and one long hold-off on request counted here
    initial
    begin
        int   stall;
        logic sink_steady;
        logic hold_done;
        sink_steady = 1'b0;
        hold_done   = 1'b0;
        out_ready   = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // main sequence
    initial
    begin
        int          k, s;
        logic [15:0] mg, rg;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        speed      = '0;
        heading    = '0;
        turn_rate  = '0;
        src_steady = 1'b0;
        hold_req   = 1'b0;
        n_cmds     = 0;
        n_settings = 1;
        n_reads    = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of both gains
        apb_xfer(APB_READ, REG_TRANS_GAIN, 32'h0);
        apb_xfer(APB_READ, REG_TURN_GAIN, 32'h0);

        // directed corners at the reset gains
        for (k = 0; k < 20; k++)
            send_cmd(DIRECTED_CMDS[k][47:32], DIRECTED_CMDS[k][31:16], DIRECTED_CMDS[k][15:0]);
        send_random(250);

        // long receiver stall while the sender keeps offering back to back,
        // enough beats to fill every stage and push back on the input
        hold_req   = 1'b1;
        src_steady = 1'b1;
        for (k = 0; k < 80; k++)
            send_cmd(rand_word(), rand_word(), rand_word());
        src_steady = 1'b0;

        // full pause until nothing is in flight, same gains afterwards
        drain_pipeline();
        send_random(100);

        // gain sweep: both extremes, mixed, random, smallest nonzero, reset value
        for (s = 0; s < 8; s++)
        begin
            case (s)
                0:       begin mg = 16'hFFFF; rg = 16'hFFFF; end
                1:       begin mg = 16'h0000; rg = 16'h0000; end
                2:       begin mg = 16'h0000; rg = 16'hFFFF; end
                3:       begin mg = 16'hFFFF; rg = 16'h0000; end
                4, 5:    begin mg = 16'($urandom); rg = 16'($urandom); end
                6:       begin mg = 16'h0001; rg = 16'h0001; end
                default: begin mg = 16'd2304; rg = 16'd1024; end
            endcase
            set_gains(mg, rg);
            // last directed commands, full-scale and smallest magnitudes, at the largest gains
            if (s == 0)
                for (k = 15; k < 20; k++)
                    send_cmd(DIRECTED_CMDS[k][47:32], DIRECTED_CMDS[k][31:16],
                             DIRECTED_CMDS[k][15:0]);
            send_random(s == 0 ? 60 : 85);
        end

        drain_pipeline();

        $display("sent %0d command beats over %0d gain settings, %0d register readbacks,",
                 n_cmds, n_settings, n_reads);
        $display("with a 300 cycle output stall, a full drain pause and random gaps both sides");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #(10_000_000);
        $display("timed out waiting for a beat, %0d wheel sets still expected", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
